// ===== hw/rtl/qte_pkg.sv =====
// quaternion to euler conversion: shared types, constants and the cordic angle table
// no dependencies
package qte_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanTabLen  = 24;
  localparam int NumIter     = (CordicSteps > AtanTabLen) ? AtanTabLen : CordicSteps;
  localparam int SqrtSteps   = 32;
  localparam int NormStages  = 6;
  localparam int AtanLat     = 1 + NormStages + NumIter;
  localparam int NumStages   = 3 + SqrtSteps + AtanLat;
  localparam int SideDepth   = SqrtSteps + 2;

  localparam int VecW = 40;

  localparam logic signed [VecW-1:0] OneQ30 = 40'sd1073741824;
  localparam logic signed [33:0]     OneQ30s = 34'sd1073741824;
  localparam logic [60:0]            OneQ60 = 61'h1000_0000_0000_0000;
  localparam logic [15:0]            PitchPos = 16'h4000;
  localparam logic [15:0]            PitchNeg = 16'hC000;
  localparam logic [14:0]            LockLimitRst = 15'd16384;

  typedef enum logic [1:0] {
    LockNone = 2'd0,
    LockPos  = 2'd1,
    LockNeg  = 2'd2
  } lock_e;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    lock_e              lock_state;
  } res_t;

  typedef struct packed {
    logic  vld;
    lock_e lock;
  } ctl_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic [31:0]            ang;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic [60:0] v;
    logic [62:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [VecW-1:0] yaw_x;
    logic signed [VecW-1:0] yaw_y;
    logic signed [VecW-1:0] roll_x;
    logic signed [VecW-1:0] roll_y;
    logic signed [31:0]     s;
  } side_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] to16(input logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h0000_8000;
    return r[31:16];
  endfunction

endpackage

// ===== hw/rtl/qte_sqrt_cell.sv =====
// one step of the bitwise integer square root, two radicand bits per cell
// depends on qte_pkg
module qte_sqrt_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [5:0]        bit_pos_i,
  input  qte_pkg::sqrt_t    st_i,
  output qte_pkg::sqrt_t    st_o
);

  qte_pkg::sqrt_t st_d, st_q;
  logic [62:0] bit_w;
  logic [63:0] trial;

  always_comb begin
    bit_w = 63'(1) << bit_pos_i;
    trial = {1'b0, st_i.res} + {1'b0, bit_w};
    st_d  = st_i;
    if ({3'b000, st_i.v} >= trial) begin
      st_d.v   = st_i.v - trial[60:0];
      st_d.res = (st_i.res >> 1) + bit_w;
    end else begin
      st_d.res = st_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

// ===== hw/rtl/qte_cordic_cell.sv =====
// one vectoring cordic rotation, registered
// depends on qte_pkg
module qte_cordic_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [4:0]        step_i,
  input  qte_pkg::cordic_t  c_i,
  output qte_pkg::cordic_t  c_o
);

  qte_pkg::cordic_t c_d, c_q;
  logic signed [qte_pkg::VecW-1:0] x, y, dx, dy;

  always_comb begin
    x   = c_i.x;
    y   = c_i.y;
    dx  = y >>> step_i;
    dy  = x >>> step_i;
    c_d = c_i;
    if (!y[qte_pkg::VecW-1]) begin
      c_d.x   = x + dx;
      c_d.y   = y - dy;
      c_d.ang = c_i.ang + qte_pkg::atan_val(step_i);
    end else begin
      c_d.x   = x - dx;
      c_d.y   = y + dy;
      c_d.ang = c_i.ang - qte_pkg::atan_val(step_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

// ===== hw/rtl/qte_atan2.sv =====
// pipelined atan2: quadrant fold, normalizing shift stages, chain of cordic cells
// depends on qte_pkg and qte_cordic_cell
module qte_atan2 (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [qte_pkg::VecW-1:0] x_i,
  input  logic signed [qte_pkg::VecW-1:0] y_i,
  output logic [31:0]                     ang_o
);

  qte_pkg::cordic_t prep_d;
  qte_pkg::cordic_t nrm_q [qte_pkg::NormStages+1];
  qte_pkg::cordic_t cst   [qte_pkg::NumIter+1];

  always_comb begin
    prep_d.zero = (x_i == '0) && (y_i == '0);
    if (x_i[qte_pkg::VecW-1]) begin
      prep_d.x   = -x_i;
      prep_d.y   = -y_i;
      prep_d.ang = 32'h8000_0000;
    end else begin
      prep_d.x   = x_i;
      prep_d.y   = y_i;
      prep_d.ang = 32'h0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nrm_q[0] <= prep_d;
    end
  end

  for (genvar j = 0; j < qte_pkg::NormStages; j++) begin : g_norm
    localparam int Amt = (j < qte_pkg::NormStages - 1) ? (16 >> j) : 1;
    localparam int LimExp = (j < qte_pkg::NormStages - 1) ? (30 - Amt) : 30;
    localparam logic [qte_pkg::VecW-1:0] Lim = 40'(1) << LimExp;
    logic [qte_pkg::VecW-1:0] ax, ay;
    qte_pkg::cordic_t n_d;
    always_comb begin
      ax  = nrm_q[j].x[qte_pkg::VecW-1] ? -nrm_q[j].x : nrm_q[j].x;
      ay  = nrm_q[j].y[qte_pkg::VecW-1] ? -nrm_q[j].y : nrm_q[j].y;
      n_d = nrm_q[j];
      if (ax < Lim && ay < Lim) begin
        n_d.x = nrm_q[j].x <<< Amt;
        n_d.y = nrm_q[j].y <<< Amt;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nrm_q[j+1] <= n_d;
      end
    end
  end

  assign cst[0] = nrm_q[qte_pkg::NormStages];

  for (genvar i = 0; i < qte_pkg::NumIter; i++) begin : g_cell
    qte_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .step_i (5'(i)),
      .c_i    (cst[i]),
      .c_o    (cst[i+1])
    );
  end

  assign ang_o = cst[qte_pkg::NumIter].zero ? 32'h0 : cst[qte_pkg::NumIter].ang;

endmodule

// ===== hw/rtl/quaternion_to_euler_unit.sv =====
// quaternion to roll, pitch and yaw binary angles with gimbal lock detection
// one item per cycle sustained while the skid stage is empty; in_stall_o holds the input otherwise
// stages: products, sums and lock test, square, 32 square root cells, cordic fold,
// 6 normalizing stages, 16 cordic cells, output register with skid stage
// asynchronous active-low reset clears valid flags and sets lock_limit to 16384
// depends on qte_pkg, qte_sqrt_cell, qte_atan2
module quaternion_to_euler_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [14:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qte_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qte_pkg::res_t  out_data_o
);

  localparam int Last = qte_pkg::NumStages - 1;

  logic [14:0] lock_limit_q;
  logic        en;

  qte_pkg::ctl_t ctl_q [qte_pkg::NumStages];
  qte_pkg::ctl_t ctl1_d;

  // stage 1: products
  logic signed [31:0] p_xy_q, p_zw_q, p_yw_q, p_xz_q, p_yy_q, p_zz_q, p_xw_q, p_yz_q, p_xx_q;
  logic signed [15:0] raw_x_q, raw_w_q;

  // stage 2: sums, lock test
  logic signed [33:0] t, lim, s2, s_sat;
  qte_pkg::side_t     side_d;
  qte_pkg::side_t     side_q [qte_pkg::SideDepth];
  logic [30:0]        mag_d, mag_q;

  // stage 3: square
  logic [60:0] sq_q;
  qte_pkg::sqrt_t sst [qte_pkg::SqrtSteps+1];

  logic [31:0] yaw_a, roll_a, pitch_a;
  logic signed [qte_pkg::VecW-1:0] c_vec;

  qte_pkg::res_t pipe_res, out_q, skid_q;
  logic          pipe_v, out_v_q, skid_v_q;
  logic [31:0]   yaw2;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_limit_q <= qte_pkg::LockLimitRst;
    end else if (cfg_valid_i) begin
      lock_limit_q <= cfg_data_i;
    end
  end

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // control line
  always_comb begin
    ctl1_d.vld = ctl_q[0].vld;
    if (t > lim) begin
      ctl1_d.lock = qte_pkg::LockPos;
    end else if (t < -lim) begin
      ctl1_d.lock = qte_pkg::LockNeg;
    end else begin
      ctl1_d.lock = qte_pkg::LockNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < qte_pkg::NumStages; k++) begin
        ctl_q[k] <= '{vld: 1'b0, lock: qte_pkg::LockNone};
      end
    end else if (en) begin
      ctl_q[0] <= '{vld: in_valid_i, lock: qte_pkg::LockNone};
      ctl_q[1] <= ctl1_d;
      for (int k = 2; k < qte_pkg::NumStages; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_xy_q  <= in_data_i.q_x * in_data_i.q_y;
      p_zw_q  <= in_data_i.q_z * in_data_i.q_w;
      p_yw_q  <= in_data_i.q_y * in_data_i.q_w;
      p_xz_q  <= in_data_i.q_x * in_data_i.q_z;
      p_yy_q  <= in_data_i.q_y * in_data_i.q_y;
      p_zz_q  <= in_data_i.q_z * in_data_i.q_z;
      p_xw_q  <= in_data_i.q_x * in_data_i.q_w;
      p_yz_q  <= in_data_i.q_y * in_data_i.q_z;
      p_xx_q  <= in_data_i.q_x * in_data_i.q_x;
      raw_x_q <= in_data_i.q_x;
      raw_w_q <= in_data_i.q_w;
    end
  end

  always_comb begin
    t   = 34'(p_xy_q) + 34'(p_zw_q);
    lim = signed'({4'b0000, lock_limit_q, 15'b0});
    s2  = t <<< 1;
    if (s2 > qte_pkg::OneQ30s) begin
      s_sat = qte_pkg::OneQ30s;
    end else if (s2 < -qte_pkg::OneQ30s) begin
      s_sat = -qte_pkg::OneQ30s;
    end else begin
      s_sat = s2;
    end
    side_d.s = 32'(s_sat);
    mag_d    = s_sat[33] ? 31'(-s_sat) : 31'(s_sat);
    if (ctl1_d.lock == qte_pkg::LockNone) begin
      side_d.yaw_x = qte_pkg::OneQ30 - ((40'(p_yy_q) + 40'(p_zz_q)) <<< 1);
      side_d.yaw_y = (40'(p_yw_q) - 40'(p_xz_q)) <<< 1;
    end else begin
      side_d.yaw_x = 40'(raw_w_q);
      side_d.yaw_y = 40'(raw_x_q);
    end
    side_d.roll_x = qte_pkg::OneQ30 - ((40'(p_xx_q) + 40'(p_zz_q)) <<< 1);
    side_d.roll_y = (40'(p_xw_q) - 40'(p_yz_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      mag_q     <= mag_d;
      sq_q      <= 61'(62'(mag_q) * 62'(mag_q));
      for (int k = 1; k < qte_pkg::SideDepth; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // square root chain
  assign sst[0].v   = qte_pkg::OneQ60 - sq_q;
  assign sst[0].res = '0;

  for (genvar i = 0; i < qte_pkg::SqrtSteps; i++) begin : g_sqrt
    qte_sqrt_cell u_sqrt (
      .clk_i     (clk_i),
      .en_i      (en),
      .bit_pos_i (6'(2 * (qte_pkg::SqrtSteps - 1 - i))),
      .st_i      (sst[i]),
      .st_o      (sst[i+1])
    );
  end

  assign c_vec = 40'(sst[qte_pkg::SqrtSteps].res[30:0]);

  qte_atan2 u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (side_q[qte_pkg::SideDepth-1].yaw_x),
    .y_i   (side_q[qte_pkg::SideDepth-1].yaw_y),
    .ang_o (yaw_a)
  );

  qte_atan2 u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (side_q[qte_pkg::SideDepth-1].roll_x),
    .y_i   (side_q[qte_pkg::SideDepth-1].roll_y),
    .ang_o (roll_a)
  );

  qte_atan2 u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (c_vec),
    .y_i   (40'(side_q[qte_pkg::SideDepth-1].s)),
    .ang_o (pitch_a)
  );

  // result assembly
  always_comb begin
    yaw2                = yaw_a << 1;
    pipe_res.lock_state = ctl_q[Last].lock;
    case (ctl_q[Last].lock)
      qte_pkg::LockPos: begin
        pipe_res.roll_angle  = '0;
        pipe_res.pitch_angle = qte_pkg::PitchPos;
        pipe_res.yaw_angle   = qte_pkg::to16(yaw2);
      end
      qte_pkg::LockNeg: begin
        pipe_res.roll_angle  = '0;
        pipe_res.pitch_angle = qte_pkg::PitchNeg;
        pipe_res.yaw_angle   = qte_pkg::to16(32'h0 - yaw2);
      end
      default: begin
        pipe_res.roll_angle  = qte_pkg::to16(roll_a);
        pipe_res.pitch_angle = qte_pkg::to16(pitch_a);
        pipe_res.yaw_angle   = qte_pkg::to16(yaw_a);
      end
    endcase
  end

  assign pipe_v = en && ctl_q[Last].vld;

  // output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      out_v_q  <= skid_v_q || pipe_v;
      skid_v_q <= 1'b0;
    end else if (pipe_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : pipe_res;
    end else if (pipe_v) begin
      skid_q <= pipe_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for quaternion_to_euler_unit: table-driven corner cases, then random
// quaternions under several idle and stall phases, checked against an in-bench angle predictor
// depends on qte_pkg and quaternion_to_euler_unit
module testbench;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [14:0]   cfg_data_i;
  logic          in_valid_i;
  logic          in_stall_o;
  qte_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  qte_pkg::res_t out_data_o;

  quaternion_to_euler_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  localparam int Steps = (16 > 24) ? 24 : 16;
  localparam longint OneQ30L = 64'sd1073741824;

  typedef struct {
    qte_pkg::in_t  q;
    bit            known;
    qte_pkg::res_t r;
  } vec_t;

  logic [14:0]   lock_thresh;
  qte_pkg::res_t pending_angles[$];
  int            errors;
  int            n_items;
  int            n_results;
  int            n_lock;
  int            send_idle_pct;
  int            stall_pct;
  vec_t          table_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30000000;
    $display("quaternion_to_euler_unit: mismatch");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [31:0] vec_angle(longint y, longint x);
    logic [31:0] acc;
    longint dx, dy;
    acc = 32'd0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    while (absl(x) < OneQ30L && absl(y) < OneQ30L) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < Steps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        acc = acc + qte_pkg::atan_val(i[4:0]);
      end else begin
        x = x - dx;
        y = y + dy;
        acc = acc - qte_pkg::atan_val(i[4:0]);
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] round_angle(logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h0000_8000;
    return r[31:16];
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic qte_pkg::res_t euler_of(qte_pkg::in_t q, logic [14:0] thresh);
    qte_pkg::res_t r;
    longint w, x, y, z, t, lim, s, c;
    longint unsigned m;
    w = longint'(q.q_w);
    x = longint'(q.q_x);
    y = longint'(q.q_y);
    z = longint'(q.q_z);
    t = x * y + z * w;
    lim = longint'({1'b0, thresh}) * 32768;
    r.roll_angle = '0;
    if (t > lim) begin
      r.yaw_angle = round_angle(32'd2 * vec_angle(x, w));
      r.pitch_angle = qte_pkg::PitchPos;
      r.lock_state = qte_pkg::LockPos;
    end else if (t < -lim) begin
      r.yaw_angle = round_angle(32'd0 - 32'd2 * vec_angle(x, w));
      r.pitch_angle = qte_pkg::PitchNeg;
      r.lock_state = qte_pkg::LockNeg;
    end else begin
      r.yaw_angle = round_angle(vec_angle(2 * (y * w - x * z), OneQ30L - 2 * (y * y + z * z)));
      r.roll_angle = round_angle(vec_angle(2 * (x * w - y * z),
                                           OneQ30L - 2 * (x * x + z * z)));
      s = 2 * t;
      if (s > OneQ30L) s = OneQ30L;
      if (s < -OneQ30L) s = -OneQ30L;
      m = longint'(absl(s));
      c = floor_sqrt((64'd1 << 60) - m * m);
      r.pitch_angle = round_angle(vec_angle(s, c));
      r.lock_state = qte_pkg::LockNone;
    end
    return r;
  endfunction

  task automatic send_quat(qte_pkg::in_t q, bit known, qte_pkg::res_t r);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_angles.push_back(known ? r : euler_of(q, lock_thresh));
    n_items++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_thresh(logic [14:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lock_thresh = v;
  endtask

  function automatic qte_pkg::in_t rand_quat(int mode);
    qte_pkg::in_t q;
    int a;
    q = qte_pkg::in_t'({$urandom, $urandom});
    if (mode == 0) begin
      // near unit: split magnitude across components
      a = $urandom_range(3, 0);
      q.q_w = 16'(int'($urandom_range(23170, 0)) * ((a & 1) ? -1 : 1));
      q.q_x = 16'(int'($urandom_range(23170, 0)) * ((a & 2) ? -1 : 1));
      q.q_y = 16'($signed(q.q_y) >>> 1);
      q.q_z = 16'($signed(q.q_z) >>> 1);
    end else if (mode == 1) begin
      // gimbal-lock region, x*y + z*w large
      q.q_x = 16'($urandom_range(32767, 16000));
      q.q_y = $urandom_range(1, 0) ? q.q_x : -q.q_x;
      q.q_w = 16'($signed(q.q_w) >>> 3);
      q.q_z = 16'($signed(q.q_z) >>> 3);
    end
    return q;
  endfunction

  function automatic vec_t row(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z, bit known, qte_pkg::res_t r);
    vec_t v;
    v.q = '{q_w: w, q_x: x, q_y: y, q_z: z};
    v.known = known;
    v.r = r;
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_angles.size() == 0) begin
          $display("%0t unexpected transfer: actual %p", $time, out_data_o);
          errors++;
        end else begin
          if (out_data_o.roll_angle !== pending_angles[0].roll_angle ||
              out_data_o.pitch_angle !== pending_angles[0].pitch_angle ||
              out_data_o.yaw_angle !== pending_angles[0].yaw_angle ||
              out_data_o.lock_state !== pending_angles[0].lock_state) begin
            $display("%0t angles differ: expected %p actual %p", $time,
                     pending_angles[0], out_data_o);
            errors++;
          end
          if (pending_angles[0].lock_state != qte_pkg::LockNone) n_lock++;
          void'(pending_angles.pop_front());
          n_results++;
        end
      end
      out_stall_i <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
    end
  end

  initial begin
    qte_pkg::res_t z0, nx;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_lock = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    lock_thresh = qte_pkg::LockLimitRst;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    z0 = '{roll_angle: 16'd0, pitch_angle: 16'd0, yaw_angle: 16'd0,
           lock_state: qte_pkg::LockNone};
    nx = '{roll_angle: 16'h8000, pitch_angle: 16'd0, yaw_angle: 16'd0,
           lock_state: qte_pkg::LockNone};
    table_rows.push_back(row(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1, z0));
    table_rows.push_back(row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, z0));
    table_rows.push_back(row(16'h0000, 16'h7fff, 16'h7fff, 16'h0000, 0, z0));
    table_rows.push_back(row(16'h0000, 16'h7fff, 16'h8001, 16'h0000, 0, z0));
    table_rows.push_back(row(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 1, nx));
    table_rows.push_back(row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, z0));
    table_rows.push_back(row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, z0));
    table_rows.push_back(row(16'h8000, 16'h0000, 16'h0000, 16'h0000, 0, z0));
    table_rows.push_back(row(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 0, z0));
    table_rows.push_back(row(16'h0000, 16'h0000, 16'h0000, 16'h8000, 0, z0));
    table_rows.push_back(row(16'h5a82, 16'h5a82, 16'h0000, 16'h0000, 0, z0));
    table_rows.push_back(row(16'h4000, 16'h4000, 16'h4000, 16'h4000, 0, z0));
    table_rows.push_back(row(16'h4000, 16'hc000, 16'h4000, 16'hc000, 0, z0));
    table_rows.push_back(row(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0, z0));
    table_rows.push_back(row(16'h0001, 16'hffff, 16'h0001, 16'hffff, 0, z0));
    table_rows.push_back(row(16'h1000, 16'h7000, 16'h2000, 16'h0800, 0, z0));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) send_quat(table_rows[i].q, table_rows[i].known, table_rows[i].r);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_thresh(15'd16384);
        1: write_thresh(15'd0);
        2: write_thresh(15'd32767);
        3: write_thresh(15'd16383);
        default: write_thresh(15'($urandom_range(32767, 0)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 46; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 46; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      for (int k = 0; k < 117; k++) begin
        if (k == 60 && ph == 3) begin
          // hold off until the pipeline is empty
          in_valid_i <= 1'b0;
          while (pending_angles.size() != 0) @(posedge clk_i);
        end
        send_quat(rand_quat($urandom_range(2, 0)), 0, z0);
      end
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    $display("sent %0d quaternions, checked %0d angle sets (%0d in gimbal lock)",
             n_items, n_results, n_lock);
    $display("lock thresholds covered 0, 16383, 16384, 32767 and random values");
    if (errors == 0) begin
      $display("quaternion_to_euler_unit: match");
    end else begin
      $display("quaternion_to_euler_unit: mismatch");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/qte_pkg.sv
hw/rtl/qte_sqrt_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/qte_atan2.sv
hw/rtl/quaternion_to_euler_unit.sv
sim/testbench.sv
